FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: label, clock, reset, antecedent, consequent
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: label, clock, reset, antecedent, consequent
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/svx_pkg.sv
`timescale 1ns / 1ps

package svx_pkg;

  localparam int GRID_SIZE = 64;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int VOXEL_W   = 6;
  localparam int Q_W       = 17;
  localparam int FRAC_W    = 16;
  localparam int D_W       = Q_W + IDX_W;
  localparam int SQ_W      = 2 * D_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int P_W       = Q_W + 1 + IDX_W;
  localparam int T_W       = IDX_W + 2;
  localparam int ROWS      = GRID_SIZE * GRID_SIZE;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SPHERE,
    OP_READ,
    OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_ZAP,
    ST_SCALE,
    ST_SQUARE,
    ST_SWEEP,
    ST_DRAIN,
    ST_LOOK,
    ST_PICK
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         mode;
    logic [Q_W-1:0]     cx;
    logic [Q_W-1:0]     cy;
    logic [Q_W-1:0]     cz;
    logic [Q_W-1:0]     r;
    logic [IDX_W-1:0]   lo_x;
    logic [IDX_W-1:0]   hi_x;
    logic [IDX_W-1:0]   lo_y;
    logic [IDX_W-1:0]   hi_y;
    logic [IDX_W-1:0]   lo_z;
    logic [IDX_W-1:0]   hi_z;
    logic [VOXEL_W-1:0] vx;
    logic [VOXEL_W-1:0] vy;
    logic [VOXEL_W-1:0] vz;
    logic               in_grid;
  } svx_item_t;

  typedef struct packed {
    logic wiping;
  } back_status_t;

  // floor((GRID_SIZE-1)*v/2^16), clamped to the grid; v is signed Q2.16
  function automatic logic [IDX_W-1:0] bound_of(input logic signed [Q_W+1:0] v);
    logic [P_W-1:0] p;
    logic [T_W-1:0] t;
    p = '0;
    t = '0;
    if (v > 0) begin
      p = P_W'(v[Q_W:0]) * P_W'(GRID_SIZE - 1);
      t = p[FRAC_W +: T_W];
    end
    if (t > T_W'(GRID_SIZE - 1)) begin
      t = T_W'(GRID_SIZE - 1);
    end
    return IDX_W'(t);
  endfunction

  // |i*2^16 - c*GRID_SIZE|
  function automatic logic [D_W-1:0] axis_dist(input logic [IDX_W-1:0] i,
                                               input logic [Q_W-1:0] c);
    logic [D_W-1:0] a;
    logic [D_W-1:0] b;
    a = D_W'({i, {FRAC_W{1'b0}}});
    b = D_W'(D_W'(c) * D_W'(GRID_SIZE));
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [ROW_AW-1:0] row_of(input logic [IDX_W-1:0] y,
                                               input logic [IDX_W-1:0] z);
    return ROW_AW'(ROW_AW'(z) * ROW_AW'(GRID_SIZE) + ROW_AW'(y));
  endfunction

endpackage

FILE: hdl/svx_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svx_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [svx_pkg::Q_W-1:0]      center_x,
  input  logic [svx_pkg::Q_W-1:0]      center_y,
  input  logic [svx_pkg::Q_W-1:0]      center_z,
  input  logic [svx_pkg::Q_W-1:0]      radius,
  input  logic [svx_pkg::VOXEL_W-1:0]  voxel_x,
  input  logic [svx_pkg::VOXEL_W-1:0]  voxel_y,
  input  logic [svx_pkg::VOXEL_W-1:0]  voxel_z,
  input  svx_pkg::back_status_t        status,
  output logic                         q_valid,
  output svx_pkg::svx_item_t           q_item,
  input  logic                         q_ready
);

  svx_pkg::svx_item_t              slots [svx_pkg::QDEPTH];
  svx_pkg::svx_item_t              item;
  logic [svx_pkg::QPTR_W-1:0]      wr_ptr;
  logic [svx_pkg::QPTR_W-1:0]      rd_ptr;
  logic [svx_pkg::QCNT_W-1:0]      count;
  logic                            push;
  logic                            pop;

  always_comb begin
    item = '0;
    case (mode)
      svx_pkg::MODE_CLEAR:  item.op = svx_pkg::OP_CLEAR;
      svx_pkg::MODE_SPHERE: item.op = svx_pkg::OP_SPHERE;
      svx_pkg::MODE_READ:   item.op = svx_pkg::OP_READ;
      default:              item.op = svx_pkg::OP_NONE;
    endcase
    item.mode = mode;
    item.cx   = center_x;
    item.cy   = center_y;
    item.cz   = center_z;
    item.r    = radius;
    item.lo_x = svx_pkg::bound_of($signed({2'b00, center_x}) - $signed({2'b00, radius}));
    item.hi_x = svx_pkg::bound_of($signed({2'b00, center_x}) + $signed({2'b00, radius}));
    item.lo_y = svx_pkg::bound_of($signed({2'b00, center_y}) - $signed({2'b00, radius}));
    item.hi_y = svx_pkg::bound_of($signed({2'b00, center_y}) + $signed({2'b00, radius}));
    item.lo_z = svx_pkg::bound_of($signed({2'b00, center_z}) - $signed({2'b00, radius}));
    item.hi_z = svx_pkg::bound_of($signed({2'b00, center_z}) + $signed({2'b00, radius}));
    item.vx   = voxel_x;
    item.vy   = voxel_y;
    item.vz   = voxel_z;
    item.in_grid = (32'(voxel_x) < svx_pkg::GRID_SIZE) &&
                   (32'(voxel_y) < svx_pkg::GRID_SIZE) &&
                   (32'(voxel_z) < svx_pkg::GRID_SIZE);
  end

  assign in_ready = !status.wiping && (count < svx_pkg::QCNT_W'(svx_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == svx_pkg::QPTR_W'(svx_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == svx_pkg::QPTR_W'(svx_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // empty or full queue: pointers must meet
  `ASSERT_IMPLIES(a_ptr_meet, clk, rst, (count == '0) || (count == svx_pkg::QCNT_W'(svx_pkg::QDEPTH)), wr_ptr == rd_ptr)
  `ASSERT_IMPLIES(a_no_wipe_push, clk, rst, status.wiping, !push)
  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, count != svx_pkg::QCNT_W'(svx_pkg::QDEPTH))

endmodule

FILE: hdl/svx_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svx_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  svx_pkg::svx_item_t    q_item,
  output logic                  q_ready,
  output svx_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  occupied,
  output logic [1:0]            done_mode
);

  svx_pkg::back_state_t             state;
  svx_pkg::back_state_t             state_next;
  svx_pkg::svx_item_t               cur;

  logic [svx_pkg::GRID_SIZE-1:0]    mem [svx_pkg::ROWS];
  logic [svx_pkg::GRID_SIZE-1:0]    rd_data;
  logic                             rd_en;
  logic [svx_pkg::ROW_AW-1:0]       rd_addr;
  logic                             wr_en;
  logic [svx_pkg::ROW_AW-1:0]       wr_addr;
  logic [svx_pkg::GRID_SIZE-1:0]    wr_mask;
  logic [svx_pkg::GRID_SIZE-1:0]    wr_data;

  logic [svx_pkg::ROW_AW-1:0]       row_cnt;
  logic                             row_last;
  logic [svx_pkg::D_W-1:0]          rs;
  logic [svx_pkg::SQ_W-1:0]         r2;

  logic [svx_pkg::IDX_W-1:0]        sx;
  logic [svx_pkg::IDX_W-1:0]        sy;
  logic [svx_pkg::IDX_W-1:0]        sz;
  logic                             x_last;
  logic                             y_last;
  logic                             z_last;
  logic                             issue;

  logic                             p1_v;
  logic [svx_pkg::D_W-1:0]          p1_dx;
  logic [svx_pkg::D_W-1:0]          p1_dy;
  logic [svx_pkg::D_W-1:0]          p1_dz;
  logic [svx_pkg::ROW_AW-1:0]       p1_row;
  logic [svx_pkg::IDX_W-1:0]        p1_bit;
  logic                             p2_v;
  logic [svx_pkg::SQ_W-1:0]         p2_sqx;
  logic [svx_pkg::SQ_W-1:0]         p2_sqy;
  logic [svx_pkg::SQ_W-1:0]         p2_sqz;
  logic [svx_pkg::ROW_AW-1:0]       p2_row;
  logic [svx_pkg::IDX_W-1:0]        p2_bit;
  logic                             p3_v;
  logic [svx_pkg::SUM_W-1:0]        p3_sum;
  logic [svx_pkg::ROW_AW-1:0]       p3_row;
  logic [svx_pkg::IDX_W-1:0]        p3_bit;

  logic                             pop;
  logic                             finish;
  logic                             fin_occ;
  logic [1:0]                       fin_mode;

  assign status.wiping = (state == svx_pkg::ST_WIPE);
  assign pop      = q_valid && q_ready;
  assign row_last = (row_cnt == svx_pkg::ROW_AW'(svx_pkg::ROWS - 1));
  assign x_last   = (sx == cur.hi_x);
  assign y_last   = (sy == cur.hi_y);
  assign z_last   = (sz == cur.hi_z);
  assign rd_addr  = svx_pkg::row_of(svx_pkg::IDX_W'(cur.vy), svx_pkg::IDX_W'(cur.vz));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svx_pkg::ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    rd_en      = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    fin_occ    = 1'b0;
    fin_mode   = cur.mode;
    case (state)
      svx_pkg::ST_WIPE: begin
        if (row_last) state_next = svx_pkg::ST_IDLE;
      end
      svx_pkg::ST_IDLE: begin
        q_ready = !out_valid;
        if (q_valid && !out_valid) begin
          case (q_item.op)
            svx_pkg::OP_CLEAR:  state_next = svx_pkg::ST_ZAP;
            svx_pkg::OP_SPHERE: state_next = svx_pkg::ST_SCALE;
            svx_pkg::OP_READ:   state_next = svx_pkg::ST_LOOK;
            default: begin
              finish   = 1'b1;
              fin_mode = q_item.mode;
            end
          endcase
        end
      end
      svx_pkg::ST_ZAP: begin
        if (row_last) begin
          finish     = 1'b1;
          state_next = svx_pkg::ST_IDLE;
        end
      end
      svx_pkg::ST_SCALE:  state_next = svx_pkg::ST_SQUARE;
      svx_pkg::ST_SQUARE: state_next = svx_pkg::ST_SWEEP;
      svx_pkg::ST_SWEEP: begin
        issue = 1'b1;
        if (x_last && y_last && z_last) state_next = svx_pkg::ST_DRAIN;
      end
      svx_pkg::ST_DRAIN: begin
        if (!p1_v && !p2_v && !p3_v) begin
          finish     = 1'b1;
          state_next = svx_pkg::ST_IDLE;
        end
      end
      svx_pkg::ST_LOOK: begin
        rd_en      = 1'b1;
        state_next = svx_pkg::ST_PICK;
      end
      svx_pkg::ST_PICK: begin
        finish     = 1'b1;
        fin_occ    = cur.in_grid && rd_data[svx_pkg::IDX_W'(cur.vx)];
        state_next = svx_pkg::ST_IDLE;
      end
      default: state_next = svx_pkg::ST_IDLE;
    endcase
  end

  // one write port: whole-row clear or a single-bit set from the sweep pipe
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p3_row;
    wr_mask = '0;
    wr_data = '1;
    if (state == svx_pkg::ST_WIPE || state == svx_pkg::ST_ZAP) begin
      wr_en   = 1'b1;
      wr_addr = row_cnt;
      wr_mask = '1;
      wr_data = '0;
    end else if (p3_v && (p3_sum < svx_pkg::SUM_W'(r2))) begin
      wr_en   = 1'b1;
      wr_mask = svx_pkg::GRID_SIZE'(1) << p3_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < svx_pkg::GRID_SIZE; i++) begin
        if (wr_mask[i]) mem[wr_addr][i] <= wr_data[i];
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (pop) begin
      row_cnt <= '0;
    end else if (state == svx_pkg::ST_WIPE || state == svx_pkg::ST_ZAP) begin
      row_cnt <= row_last ? '0 : row_cnt + 1'b1;
    end
  end

  // item registers and sweep position
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
      sx  <= q_item.lo_x;
      sy  <= q_item.lo_y;
      sz  <= q_item.lo_z;
    end else if (issue) begin
      if (!x_last) begin
        sx <= sx + 1'b1;
      end else begin
        sx <= cur.lo_x;
        if (!y_last) begin
          sy <= sy + 1'b1;
        end else begin
          sy <= cur.lo_y;
          sz <= sz + 1'b1;
        end
      end
    end
    if (state == svx_pkg::ST_SCALE) begin
      rs <= svx_pkg::D_W'(svx_pkg::D_W'(cur.r) * svx_pkg::D_W'(svx_pkg::GRID_SIZE));
    end
    if (state == svx_pkg::ST_SQUARE) begin
      r2 <= rs * rs;
    end
  end

  // inside test: distances, squares, sum, compare at the write port
  always_ff @(posedge clk) begin
    p1_dx  <= svx_pkg::axis_dist(sx, cur.cx);
    p1_dy  <= svx_pkg::axis_dist(sy, cur.cy);
    p1_dz  <= svx_pkg::axis_dist(sz, cur.cz);
    p1_row <= svx_pkg::row_of(sy, sz);
    p1_bit <= sx;
    p2_sqx <= p1_dx * p1_dx;
    p2_sqy <= p1_dy * p1_dy;
    p2_sqz <= p1_dz * p1_dz;
    p2_row <= p1_row;
    p2_bit <= p1_bit;
    p3_sum <= svx_pkg::SUM_W'(p2_sqx) + svx_pkg::SUM_W'(p2_sqy) + svx_pkg::SUM_W'(p2_sqz);
    p3_row <= p2_row;
    p3_bit <= p2_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      occupied  <= fin_occ;
      done_mode <= fin_mode;
    end
  end

  `ASSERT_IMPLIES(a_pop_out_free, clk, rst, pop, !out_valid)
  `ASSERT_IMPLIES(a_write_src, clk, rst, wr_en, (state == svx_pkg::ST_WIPE) || (state == svx_pkg::ST_ZAP) || p3_v)
  `ASSERT_NEXT(a_drain_empty, clk, rst, (state == svx_pkg::ST_DRAIN) && (state_next == svx_pkg::ST_IDLE), !p1_v && !p2_v && !p3_v)
  `ASSERT_IMPLIES(a_sweep_in_box, clk, rst, state == svx_pkg::ST_SWEEP, (sx >= cur.lo_x) && (sx <= cur.hi_x) && (sy >= cur.lo_y) && (sy <= cur.hi_y) && (sz >= cur.lo_z) && (sz <= cur.hi_z))

endmodule

FILE: hdl/sphere_voxelizer_unit.sv
`timescale 1ns / 1ps
// Sphere voxelizer: a 64x64x64 occupancy bitmap held in a row memory
// (one 64-bit row per y,z pair).
// Input channel in_valid/in_ready carries one command word: mode 0 clears
// the map, mode 1 marks every voxel of the sphere's bounding box whose point
// lies strictly inside the sphere, mode 2 reads one voxel, mode 3 is a no-op.
// Output channel out_valid/out_ready returns one word per command: occupied
// (read result, else 0) and done_mode.
// A front end classifies commands and works out the voxel bounding box; a
// two-word queue lets it keep accepting while the back end is busy.
// Back-end work per command: clear writes all 4096 rows, one row per cycle;
// read looks up the row and then picks the bit; a no-op finishes at once;
// sphere scales and squares the radius, then sweeps the box, testing one
// voxel per cycle through a three-stage distance/square/sum pipe, and drains
// the pipe. The result word is registered; the next command starts the cycle
// after the result word is taken, so a new command waits for the last result.
// After reset the back end clears all 4096 rows with in_ready low.
// A stalled out_ready holds the result word and stops the back end
// taking the next command; the front keeps filling its queue until full.

module sphere_voxelizer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [svx_pkg::Q_W-1:0]      center_x,
  input  logic [svx_pkg::Q_W-1:0]      center_y,
  input  logic [svx_pkg::Q_W-1:0]      center_z,
  input  logic [svx_pkg::Q_W-1:0]      radius,
  input  logic [svx_pkg::VOXEL_W-1:0]  voxel_x,
  input  logic [svx_pkg::VOXEL_W-1:0]  voxel_y,
  input  logic [svx_pkg::VOXEL_W-1:0]  voxel_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         occupied,
  output logic [1:0]                   done_mode
);

  logic                  q_valid;
  logic                  q_ready;
  svx_pkg::svx_item_t    q_item;
  svx_pkg::back_status_t status;

  svx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .radius   (radius),
    .voxel_x  (voxel_x),
    .voxel_y  (voxel_y),
    .voxel_z  (voxel_z),
    .status   (status),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  svx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .occupied  (occupied),
    .done_mode (done_mode)
  );

endmodule

FILE: tb/sphere_voxelizer_unit_tb.sv
`timescale 1ns / 1ps

module sphere_voxelizer_unit_tb;

  localparam int          GRID         = svx_pkg::GRID_SIZE;
  localparam int          RANDOM_ITEMS = 556;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam longint      TIMEOUT_NS   = 64'd60_000_000;
  localparam logic [16:0] Q_MAX        = 17'h1FFFF;
  localparam logic [16:0] Q_HALF       = 17'd32768;
  localparam logic [16:0] Q_UNIT       = 17'd65536;

  typedef struct packed {
    svx_pkg::op_t op;
    logic [16:0]  cx;
    logic [16:0]  cy;
    logic [16:0]  cz;
    logic [16:0]  r;
    logic [5:0]   vx;
    logic [5:0]   vy;
    logic [5:0]   vz;
  } voxel_cmd_t;

  typedef struct packed {
    logic       occ;
    logic [1:0] dm;
  } voxel_word_t;

  // Mirror of the occupancy map plus the result words still owed by the block
  class voxel_map_scoreboard;
    bit [GRID-1:0] rows [GRID*GRID];
    voxel_word_t   awaited_words [$];
    int unsigned   faults;

    function new();
      foreach (rows[i]) rows[i] = '0;
      faults = 0;
    endfunction

    // floor((GRID-1)*v/2^16), clamped to the grid
    function int unsigned box_limit(longint v);
      longint t;
      if (v <= 0) return 0;
      t = (v * (GRID - 1)) >>> 16;
      if (t > GRID - 1) t = GRID - 1;
      return int'(t);
    endfunction

    function longint unsigned axis_term(int unsigned i, longint unsigned c);
      longint unsigned a;
      longint unsigned b;
      longint unsigned d;
      a = longint'(i) << 16;
      b = c * GRID;
      d = (a >= b) ? a - b : b - a;
      return d * d;
    endfunction

    function void mark_sphere(logic [16:0] cx, logic [16:0] cy, logic [16:0] cz,
                              logic [16:0] r);
      longint unsigned c [3];
      int unsigned     lo [3];
      int unsigned     hi [3];
      longint unsigned rs;
      longint unsigned r2;
      longint unsigned dz;
      longint unsigned dyz;
      c[0] = cx;
      c[1] = cy;
      c[2] = cz;
      for (int k = 0; k < 3; k++) begin
        lo[k] = box_limit(longint'(c[k]) - longint'(r));
        hi[k] = box_limit(longint'(c[k]) + longint'(r));
      end
      rs = longint'(r) * GRID;
      r2 = rs * rs;
      for (int unsigned z = lo[2]; z <= hi[2]; z++) begin
        dz = axis_term(z, c[2]);
        for (int unsigned y = lo[1]; y <= hi[1]; y++) begin
          dyz = dz + axis_term(y, c[1]);
          for (int unsigned x = lo[0]; x <= hi[0]; x++) begin
            if (dyz + axis_term(x, c[0]) < r2) rows[z*GRID + y][x] = 1'b1;
          end
        end
      end
    endfunction

    function void note_command(voxel_cmd_t c);
      voxel_word_t w;
      w.occ = 1'b0;
      w.dm  = c.op;
      case (c.op)
        svx_pkg::OP_CLEAR:  foreach (rows[i]) rows[i] = '0;
        svx_pkg::OP_SPHERE: mark_sphere(c.cx, c.cy, c.cz, c.r);
        svx_pkg::OP_READ:   w.occ = rows[int'(c.vz)*GRID + int'(c.vy)][c.vx];
        default:   ;
      endcase
      awaited_words = {awaited_words, w};
    endfunction

    function void check_word(logic occ, logic [1:0] dm);
      voxel_word_t w;
      if (awaited_words.size() == 0) begin
        $error("result word with none awaited: occupied=%0d done_mode=%0d", occ, dm);
        faults++;
        return;
      end
      w = awaited_words.pop_front();
      if (occ !== w.occ) begin
        $error("occupied: expected %0d, got %0d", w.occ, occ);
        faults++;
      end
      if (dm !== w.dm) begin
        $error("done_mode: expected %0d, got %0d", w.dm, dm);
        faults++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  mode      = '0;
  logic [16:0] center_x  = '0;
  logic [16:0] center_y  = '0;
  logic [16:0] center_z  = '0;
  logic [16:0] radius    = '0;
  logic [5:0]  voxel_x   = '0;
  logic [5:0]  voxel_y   = '0;
  logic [5:0]  voxel_z   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        occupied;
  logic [1:0]  done_mode;

  bit calm     = 1'b0;
  bit hold_out = 1'b0;

  voxel_map_scoreboard tracker;

  sphere_voxelizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .radius    (radius),
    .voxel_x   (voxel_x),
    .voxel_y   (voxel_y),
    .voxel_z   (voxel_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .occupied  (occupied),
    .done_mode (done_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      tracker.note_command('{svx_pkg::op_t'(mode), center_x, center_y, center_z, radius,
                             voxel_x, voxel_y, voxel_z});
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_word(occupied, done_mode);
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_command(input voxel_cmd_t c);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    mode     <= c.op;
    center_x <= c.cx;
    center_y <= c.cy;
    center_z <= c.cz;
    radius   <= c.r;
    voxel_x  <= c.vx;
    voxel_y  <= c.vy;
    voxel_z  <= c.vz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic voxel_cmd_t make_cmd(svx_pkg::op_t op, logic [16:0] cx,
                                          logic [16:0] cy,
                                          logic [16:0] cz, logic [16:0] r,
                                          logic [5:0] vx, logic [5:0] vy,
                                          logic [5:0] vz);
    voxel_cmd_t c;
    c = '{op, cx, cy, cz, r, vx, vy, vz};
    return c;
  endfunction

  // index near a centre coordinate, clamped into the grid
  function automatic logic [5:0] near_index(logic [16:0] c);
    int v;
    v = int'(c >> 10) + $urandom_range(6) - 3;
    if (v < 0) v = 0;
    if (v > GRID - 1) v = GRID - 1;
    return 6'(v);
  endfunction

  initial begin
    voxel_cmd_t  c;
    voxel_cmd_t  last_sphere;
    int unsigned roll;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 63, 63, 63));
    send_command(make_cmd(svx_pkg::OP_NONE,   Q_MAX, Q_MAX, Q_MAX, Q_MAX, 63, 63, 63));
    // zero radius marks nothing
    send_command(make_cmd(svx_pkg::OP_SPHERE, Q_HALF, Q_HALF, Q_HALF, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 32, 32, 32));
    // lower bound below zero
    send_command(make_cmd(svx_pkg::OP_SPHERE, 0, 0, 0, 17'd8192, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 7, 0, 0));
    send_command(make_cmd(svx_pkg::OP_SPHERE, Q_HALF, Q_HALF, Q_HALF, 17'd4096, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 32, 32, 32));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 35, 32, 32));
    // values above one, bounds clamp to the top of the grid
    send_command(make_cmd(svx_pkg::OP_SPHERE, Q_MAX, Q_MAX, Q_MAX, 17'd70000, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 63, 63, 63));
    send_command(make_cmd(svx_pkg::OP_SPHERE, Q_UNIT, Q_UNIT, Q_UNIT, 17'd2048, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 63, 63, 63));
    send_command(make_cmd(svx_pkg::OP_CLEAR,  0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 32, 32, 32));
    // whole grid in one sphere
    send_command(make_cmd(svx_pkg::OP_SPHERE, Q_HALF, Q_HALF, Q_HALF, Q_MAX, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 0, 63, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 63, 0, 63));
    send_command(make_cmd(svx_pkg::OP_NONE,   0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_CLEAR,  0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(svx_pkg::OP_READ,   0, 0, 0, 0, 63, 63, 63));

    last_sphere = make_cmd(svx_pkg::OP_SPHERE, Q_HALF, Q_HALF, Q_HALF, 17'd4096,
                           0, 0, 0);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_out = 1'b1;
      if (n == 300) begin
        // nothing on offer while the block empties
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.awaited_words.size() != 0);
      end
      calm = (n >= 380 && n < 460);

      // unused fields carry noise
      c = make_cmd(svx_pkg::OP_READ, 17'($urandom_range(131071)),
                   17'($urandom_range(131071)),
                   17'($urandom_range(131071)), 17'($urandom_range(131071)),
                   6'($urandom_range(63)), 6'($urandom_range(63)),
                   6'($urandom_range(63)));
      roll = $urandom_range(99);
      if (roll < 4) begin
        c.op = svx_pkg::OP_CLEAR;
      end else if (roll < 7) begin
        c.op = svx_pkg::OP_NONE;
      end else if (roll < 37) begin
        c.op = svx_pkg::OP_SPHERE;
        if ($urandom_range(7) == 0) begin
          // far out with a radius above one: small clamped box
          c.cx = 17'($urandom_range(131071, 126000));
          c.cy = 17'($urandom_range(131071, 126000));
          c.cz = 17'($urandom_range(131071, 126000));
          c.r  = 17'($urandom_range(69000, 65536));
        end else begin
          if ($urandom_range(4) != 0) begin
            c.cx = 17'($urandom_range(65536));
            c.cy = 17'($urandom_range(65536));
            c.cz = 17'($urandom_range(65536));
          end
          c.r = 17'($urandom_range(6143));
        end
        last_sphere = c;
      end else if (roll < 80) begin
        c.vx = near_index(last_sphere.cx);
        c.vy = near_index(last_sphere.cy);
        c.vz = near_index(last_sphere.cz);
      end
      send_command(c);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (tracker.awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
